>>> design/timer_event_queue_top_macros.svh
// Assertion macros shared by the timer event queue design.
`ifndef TIMER_EVENT_QUEUE_TOP_MACROS_SVH
`define TIMER_EVENT_QUEUE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer queue check failed");
// Next-cycle implication checked outside reset.
`define TEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer queue check failed");
`endif

>>> design/teq_pkg.sv
// Shared types and constants of the timer event queue.
package teq_pkg;
  localparam int Capacity  = 32;
  localparam int IdWidth   = 8;
  localparam int MaxFire   = 32;
  localparam int CntW      = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    FUNC_ATTACH = 2'd0,
    FUNC_DETACH = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ABSENT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_FIRE,
    S_OUT
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the request and search the table
    logic remove;    // delete the slot found by the search
    logic insert;    // insert the captured event
    logic pop;       // fire the head slot
    status_t res_status;
    logic res_last;
  } teq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    func_t func;
    logic  found;
    logic  full;        // table full after removal of a found id
    logic  head_due;
    logic  next_due;    // the slot behind the head is also due
    logic [CntW-1:0] occ;
  } teq_stat_t;
endpackage

>>> design/teq_datapath.sv
// Datapath: ordered slot table with shift insert/remove and result register.
module teq_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  teq_pkg::teq_cmd_t         cmd,
  output teq_pkg::teq_stat_t        stat,
  input  logic [1:0]                in_func,
  input  logic [7:0]                in_event_id,
  input  logic [63:0]               in_time_value,
  output logic [1:0]                res_status,
  output logic                      res_fired_valid,
  output logic [7:0]                res_fired_id,
  output logic [63:0]               res_fired_time,
  output logic [5:0]                res_pending_count,
  output logic                      res_last,
  input  logic                      res_load
);
  localparam int N = teq_pkg::Capacity;
  localparam int W = teq_pkg::IdWidth;

  logic [63:0]  exp_r [N];
  logic [W-1:0] ev_r  [N];
  logic [teq_pkg::CntW-1:0] occ_r, occ_nxt;
  logic [1:0]   func_r;
  logic [W-1:0] id_r;
  logic [63:0]  t_r;
  logic         found_r;
  logic [N-1:0] hit_r;   // one-hot position of the matching slot

  logic [N-1:0] le_vec;  // slot holds an expiry at or before the new time
  logic [N-1:0] hit_c;
  logic         pend_fire;
  logic [W-1:0] pop_id;
  logic [63:0]  pop_t;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_c[i]  = (i < occ_r) && (ev_r[i] == in_event_id[W-1:0]);
      le_vec[i] = (i < occ_r) && (exp_r[i] <= t_r);
    end
  end

  assign stat.func     = teq_pkg::func_t'(func_r);
  assign stat.found    = found_r;
  assign stat.full     = (occ_r == teq_pkg::CntW'(N));
  assign stat.head_due = (occ_r != '0) && (exp_r[0] <= t_r);
  assign stat.next_due = (occ_r > teq_pkg::CntW'(1)) && (exp_r[1] <= t_r);
  assign stat.occ      = occ_r;

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.remove || cmd.pop) occ_nxt = occ_r - 1'b1;
    if (cmd.insert) occ_nxt = occ_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      id_r    <= in_event_id[W-1:0];
      t_r     <= in_time_value;
      hit_r   <= hit_c;
      found_r <= |hit_c;
    end
    if (cmd.remove || cmd.pop) begin
      // Slots at or after the removed one move down by one.
      for (int i = 0; i < N - 1; i++) begin
        if (cmd.pop || (|(hit_r & ((N)'(1) << i) - 1'b1) ^ 1'b1) == 1'b0 || hit_r[i]
            || (|(hit_r & (((N)'(1) << i) - 1'b1)))) begin
          exp_r[i] <= exp_r[i+1];
          ev_r[i]  <= ev_r[i+1];
        end
      end
    end
    if (cmd.insert) begin
      // Insert behind every slot whose expiry is not later.
      if (!le_vec[0]) begin
        exp_r[0] <= t_r;
        ev_r[0]  <= id_r;
      end
      for (int i = 1; i < N; i++) begin
        if (!le_vec[i] && i <= occ_r) begin
          if (le_vec[i-1]) begin
            exp_r[i] <= t_r;
            ev_r[i]  <= id_r;
          end else begin
            exp_r[i] <= exp_r[i-1];
            ev_r[i]  <= ev_r[i-1];
          end
        end
      end
    end
  end

  assign pop_id    = ev_r[0];
  assign pop_t     = exp_r[0];
  assign pend_fire = cmd.pop;

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status        <= pend_fire ? teq_pkg::ST_OK : cmd.res_status;
      res_fired_valid   <= pend_fire;
      res_fired_id      <= pend_fire ? 8'(pop_id) : 8'd0;
      res_fired_time    <= pend_fire ? pop_t : 64'd0;
      res_pending_count <= 6'(occ_nxt);
      res_last          <= cmd.res_last;
    end
  end
endmodule

>>> design/teq_ctrl.sv
// Controller state machine sequencing search, update and result delivery.
module teq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  teq_pkg::teq_stat_t   stat,
  output teq_pkg::teq_cmd_t    cmd,
  output logic                 res_load
);
  teq_pkg::ctl_state_t state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic [5:0] fired_r, fired_nxt;
  logic       slot_free;
  logic       more;

  assign slot_free = !ov_r || !out_stall;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= teq_pkg::S_IDLE;
      ov_r    <= 1'b0;
      fired_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      fired_r <= fired_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = teq_pkg::ST_OK;
    res_load       = 1'b0;
    fired_nxt      = fired_r;
    ov_nxt         = ov_r && out_stall;
    in_stall       = 1'b1;
    more           = 1'b0;
    case (state_r)
      teq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          fired_nxt = '0;
          state_nxt = teq_pkg::S_INSERT;
        end
      end
      teq_pkg::S_INSERT: begin
        case (stat.func)
          teq_pkg::FUNC_ATTACH, teq_pkg::FUNC_DETACH: begin
            if (stat.found) begin
              cmd.remove = 1'b1;
              state_nxt  = teq_pkg::S_OUT;
            end else begin
              state_nxt = teq_pkg::S_OUT;
            end
          end
          teq_pkg::FUNC_TICK: state_nxt = teq_pkg::S_FIRE;
          default: state_nxt = teq_pkg::S_OUT;
        endcase
      end
      teq_pkg::S_FIRE: begin
        if (slot_free) begin
          more = stat.head_due && (fired_r < 6'(teq_pkg::MaxFire));
          res_load = 1'b1;
          ov_nxt   = 1'b1;
          if (more) begin
            cmd.pop      = 1'b1;
            fired_nxt    = fired_r + 1'b1;
            cmd.res_last = !stat.next_due || (fired_r + 1'b1 == 6'(teq_pkg::MaxFire));
            if (cmd.res_last) state_nxt = teq_pkg::S_IDLE;
          end else if (fired_r == '0) begin
            cmd.res_last = 1'b1;
            state_nxt    = teq_pkg::S_IDLE;
          end else begin
            // Previous fire was not flagged last; cannot happen with lookahead.
            res_load     = 1'b0;
            ov_nxt       = ov_r && out_stall;
            state_nxt    = teq_pkg::S_IDLE;
          end
        end
      end
      teq_pkg::S_OUT: begin
        if (slot_free) begin
          res_load     = 1'b1;
          ov_nxt       = 1'b1;
          cmd.res_last = 1'b1;
          state_nxt    = teq_pkg::S_IDLE;
          if (stat.func == teq_pkg::FUNC_ATTACH) begin
            if (stat.full) cmd.res_status = teq_pkg::ST_FULL;
            else           cmd.insert     = 1'b1;
          end else if (stat.func == teq_pkg::FUNC_DETACH && !stat.found) begin
            cmd.res_status = teq_pkg::ST_ABSENT;
          end
        end
      end
      default: state_nxt = teq_pkg::S_IDLE;
    endcase
  end
endmodule

>>> design/timer_event_queue_top.sv
// Top level of the timer event queue.
// Channel | Direction | Handshake
// in_     | request   | in_valid / in_stall
// out_    | result    | out_valid / out_stall
// Attach and detach: the request is searched on accept, a found id is removed
// in the insert state, and the output state inserts an attached event if the
// table is not full and registers the result; requests are taken in idle.
// A tick goes from the insert state to the fire state, which registers one
// result per fired event. Reset is synchronous and clears the occupancy, so
// no table clearing pass is needed. A stalled result holds the sequencer.
`include "timer_event_queue_top_macros.svh"
module timer_event_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_event_id,
  input  logic [63:0] in_time_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_fired_valid,
  output logic [7:0]  out_fired_id,
  output logic [63:0] out_fired_time,
  output logic [5:0]  out_pending_count,
  output logic        out_last
);
  teq_pkg::teq_cmd_t  cmd;
  teq_pkg::teq_stat_t stat;
  logic               res_load;

  teq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd, .res_load
  );

  teq_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .in_func, .in_event_id, .in_time_value,
    .res_status(out_status), .res_fired_valid(out_fired_valid),
    .res_fired_id(out_fired_id), .res_fired_time(out_fired_time),
    .res_pending_count(out_pending_count), .res_last(out_last), .res_load
  );

  `TEQ_ASSERT_IMP(a_occ_bound, 1'b1, stat.occ <= teq_pkg::Capacity)
  `TEQ_ASSERT_NXT(a_hold_on_stall, out_valid && out_stall, out_valid)
  `TEQ_ASSERT_IMP(a_no_load_on_stall, out_valid && out_stall, !res_load)
endmodule
